// File: rtl/core/mcuid_pkg.sv
// Types, codes and decode helpers for the instruction decoder.
// No dependencies; imported by every RTL module of the decoder.
package mcuid_pkg;

  typedef enum logic [2:0] {
    MODE_REG = 3'd0,
    MODE_IDX = 3'd1,
    MODE_SYM = 3'd2,
    MODE_ABS = 3'd3,
    MODE_IND = 3'd4,
    MODE_INC = 3'd5,
    MODE_IMM = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    FMT_DOUBLE = 2'd0,
    FMT_SINGLE = 2'd1,
    FMT_JUMP   = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    KIND_ILL,
    KIND_SGL,
    KIND_JMP,
    KIND_DBL
  } kind_e;

  localparam logic [3:0] OP_RRC  = 4'd0;
  localparam logic [3:0] OP_SWPB = 4'd2;
  localparam logic [3:0] OP_RRA  = 4'd3;
  localparam logic [3:0] OP_SXT  = 4'd5;
  localparam logic [3:0] OP_PUSH = 4'd6;
  localparam logic [3:0] OP_CALL = 4'd8;
  localparam logic [3:0] OP_RETI = 4'd9;

  localparam logic [5:0] OP_JUMP_BASE   = 6'd10;
  localparam logic [5:0] OP_DOUBLE_BASE = 6'd18;

  localparam logic [3:0] TOP_SINGLE = 4'h1;
  localparam logic [3:0] TOP_JUMP0  = 4'h2;
  localparam logic [3:0] TOP_JUMP1  = 4'h3;
  localparam logic [3:0] TOP_MOV    = 4'h4;

  localparam logic [3:0] REG_PC = 4'd0;
  localparam logic [3:0] REG_SR = 4'd2;

  localparam logic [2:0] LEN_SHORT = 3'd2;

  // stage 1 -> stage 2
  typedef struct packed {
    kind_e      kind;
    mode_e      sm;
    mode_e      dm;
    logic       sop_ok;
    logic [3:0] sop;
    logic [5:0] op;
    logic       bop;
    logic       pc_dst;
  } s1_t;

  // stage 2 -> output stage
  typedef struct packed {
    logic       ill;
    fmt_e       fmt;
    logic [5:0] op;
    logic       bop;
    mode_e      sm;
    mode_e      dm;
    logic [2:0] len;
    logic       pc_dst;
  } s2_t;

  function automatic mode_e addr_mode(input logic [1:0] bits, input logic [3:0] rn);
    mode_e m;
    unique case (bits)
      2'b00: m = MODE_REG;
      2'b01: m = (rn == REG_PC) ? MODE_SYM : ((rn == REG_SR) ? MODE_ABS : MODE_IDX);
      2'b10: m = MODE_IND;
      default: m = (rn == REG_PC) ? MODE_IMM : MODE_INC;
    endcase
    return m;
  endfunction

  function automatic logic needs_word(input mode_e m);
    return (m == MODE_IDX) || (m == MODE_SYM) || (m == MODE_ABS) || (m == MODE_IMM);
  endfunction

  // {valid, op}
  function automatic logic [4:0] single_op(input logic [5:0] key);
    logic [4:0] r;
    unique case (key)
      6'd0:    r = {1'b1, 4'd0};
      6'd1:    r = {1'b1, 4'd1};
      6'd2:    r = {1'b1, 4'd2};
      6'd4:    r = {1'b1, 4'd3};
      6'd5:    r = {1'b1, 4'd4};
      6'd6:    r = {1'b1, 4'd5};
      6'd8:    r = {1'b1, 4'd6};
      6'd9:    r = {1'b1, 4'd7};
      6'd10:   r = {1'b1, 4'd8};
      6'd12:   r = {1'b1, 4'd9};
      default: r = {1'b0, 4'd0};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/mcuid_if.sv
// Valid/ready channel interfaces for the instruction decoder.
// No dependencies.
interface mcuid_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mcuid_out_if;
  logic       valid;
  logic       ready;
  logic       illegal;
  logic [1:0] format;
  logic [5:0] operation;
  logic       byte_op;
  logic [2:0] source_mode;
  logic [2:0] dest_mode;
  logic [2:0] length_bytes;
  logic [2:0] cycle_count;

  modport source (output valid, output illegal, output format, output operation,
                  output byte_op, output source_mode, output dest_mode,
                  output length_bytes, output cycle_count, input ready);
  modport sink   (input valid, input illegal, input format, input operation,
                  input byte_op, input source_mode, input dest_mode,
                  input length_bytes, input cycle_count, output ready);
endinterface

// File: rtl/core/mcuid_timing.sv
// Execution cycle count lookup from format, operation and addressing modes.
// Depends on mcuid_pkg.
module mcuid_timing (
  input  mcuid_pkg::s2_t  dec_i,
  output logic [2:0]      cycles_o
);
  import mcuid_pkg::*;

  logic       dst_reg;
  logic [1:0] cls;
  logic [3:0] sop;

  assign dst_reg = (dec_i.dm == MODE_REG);
  assign sop     = dec_i.op[3:0];

  always_comb begin
    if (sop < OP_PUSH) begin
      cls = 2'd0;
    end else if (sop < OP_CALL) begin
      cls = 2'd1;
    end else begin
      cls = 2'd2;
    end
  end

  always_comb begin
    cycles_o = 3'd2;
    unique case (dec_i.fmt)
      FMT_JUMP: cycles_o = 3'd2;
      FMT_SINGLE: begin
        if (sop == OP_RETI) begin
          cycles_o = 3'd5;
        end else begin
          case (dec_i.sm)
            MODE_REG: cycles_o = (cls == 2'd0) ? 3'd1 : ((cls == 2'd1) ? 3'd3 : 3'd4);
            MODE_IND: cycles_o = (cls == 2'd0) ? 3'd3 : 3'd4;
            MODE_INC: cycles_o = (cls == 2'd0) ? 3'd3 : 3'd5;
            MODE_IMM: cycles_o = (cls == 2'd1) ? 3'd4 : 3'd5;
            default:  cycles_o = (cls == 2'd0) ? 3'd4 : 3'd5;
          endcase
        end
      end
      default: begin
        case (dec_i.sm)
          MODE_REG: cycles_o = dst_reg ? (dec_i.pc_dst ? 3'd2 : 3'd1) : 3'd4;
          MODE_IND: cycles_o = dst_reg ? 3'd2 : 3'd5;
          MODE_INC, MODE_IMM: cycles_o = dst_reg ? (dec_i.pc_dst ? 3'd3 : 3'd2) : 3'd5;
          default:  cycles_o = dst_reg ? 3'd3 : 3'd6;
        endcase
      end
    endcase
  end

endmodule

// File: rtl/core/mcu_instruction_decoder_top.sv
// Instruction decoder top level: three-stage valid/ready pipeline.
// Depends on mcuid_pkg, mcuid_if and mcuid_timing.
//
// Takes one 16-bit instruction word per cycle unless stalled and returns its format, operation,
// byte flag, addressing modes, length in bytes and cycle count, or the illegal flag with all
// other fields zero. The result passes through three register stages, the first loaded at the
// input transfer edge: field and mode extraction, then legality and length, then the timing
// lookup into the output register. Sustained rate is one word per cycle; each stage holds while
// the stage after it is full and stalled, so the input is refused only when all three stages
// hold words and the output is not being taken.
module mcu_instruction_decoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  mcuid_in_if.sink         in_i,
  mcuid_out_if.source      out_o
);
  import mcuid_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic adv1, adv2, adv3;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;

  logic        ill3_q;
  fmt_e        fmt3_q;
  logic [5:0]  op3_q;
  logic        bop3_q;
  mode_e       sm3_q, dm3_q;
  logic [2:0]  len3_q, cyc3_q;
  logic [2:0]  cyc;

  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_i.ready = adv1;

  assign v1_d = adv1 ? in_i.valid : v1_q;
  assign v2_d = adv2 ? v1_q : v2_q;
  assign v3_d = adv3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // stage 1: class, modes, raw op numbers
  always_comb begin
    logic [15:0] w;
    logic [3:0]  top;
    logic [4:0]  sop;
    w   = in_i.instruction_word;
    top = w[15:12];
    sop = single_op(w[11:6]);
    s1_d.sop_ok = sop[4];
    s1_d.sop    = sop[3:0];
    s1_d.pc_dst = (w[3:0] == REG_PC);
    s1_d.bop    = w[6];
    s1_d.op     = OP_DOUBLE_BASE + {1'b0, (top - TOP_MOV), w[6]};
    s1_d.sm     = addr_mode(w[5:4], w[11:8]);
    s1_d.dm     = addr_mode({1'b0, w[7]}, w[3:0]);
    s1_d.kind   = KIND_DBL;
    unique case (top)
      4'h0: s1_d.kind = KIND_ILL;
      TOP_SINGLE: begin
        s1_d.kind = KIND_SGL;
        s1_d.sm   = addr_mode(w[5:4], w[3:0]);
        s1_d.dm   = s1_d.sm;
      end
      TOP_JUMP0, TOP_JUMP1: begin
        s1_d.kind = KIND_JMP;
        s1_d.sm   = MODE_REG;
        s1_d.dm   = MODE_REG;
        s1_d.bop  = 1'b0;
        s1_d.op   = OP_JUMP_BASE + {3'd0, top[0], w[11:10]};
      end
      default: s1_d.kind = KIND_DBL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: legality, final op, length
  always_comb begin
    logic imm_bad;
    imm_bad = (s1_q.sm == MODE_IMM) && ((s1_q.sop == OP_RRC) || (s1_q.sop == OP_SWPB) ||
                                        (s1_q.sop == OP_RRA) || (s1_q.sop == OP_SXT));
    s2_d.ill    = 1'b0;
    s2_d.fmt    = FMT_DOUBLE;
    s2_d.op     = s1_q.op;
    s2_d.bop    = s1_q.bop;
    s2_d.sm     = s1_q.sm;
    s2_d.dm     = s1_q.dm;
    s2_d.pc_dst = s1_q.pc_dst;
    s2_d.len    = LEN_SHORT + (needs_word(s1_q.sm) ? 3'd2 : 3'd0)
                  + (needs_word(s1_q.dm) ? 3'd2 : 3'd0);
    unique case (s1_q.kind)
      KIND_ILL: s2_d.ill = 1'b1;
      KIND_SGL: begin
        s2_d.ill = !s1_q.sop_ok || imm_bad;
        s2_d.fmt = FMT_SINGLE;
        s2_d.op  = {2'd0, s1_q.sop};
        s2_d.len = LEN_SHORT + (needs_word(s1_q.sm) ? 3'd2 : 3'd0);
      end
      KIND_JMP: begin
        s2_d.fmt = FMT_JUMP;
        s2_d.len = LEN_SHORT;
      end
      default: s2_d.fmt = FMT_DOUBLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: timing lookup into the output register
  mcuid_timing u_timing (
    .dec_i    (s2_q),
    .cycles_o (cyc)
  );

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      ill3_q <= s2_q.ill;
      fmt3_q <= s2_q.ill ? FMT_DOUBLE : s2_q.fmt;
      op3_q  <= s2_q.ill ? 6'd0 : s2_q.op;
      bop3_q <= s2_q.ill ? 1'b0 : s2_q.bop;
      sm3_q  <= s2_q.ill ? MODE_REG : s2_q.sm;
      dm3_q  <= s2_q.ill ? MODE_REG : s2_q.dm;
      len3_q <= s2_q.ill ? 3'd0 : s2_q.len;
      cyc3_q <= s2_q.ill ? 3'd0 : cyc;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.illegal      = ill3_q;
  assign out_o.format       = fmt3_q;
  assign out_o.operation    = op3_q;
  assign out_o.byte_op      = bop3_q;
  assign out_o.source_mode  = sm3_q;
  assign out_o.dest_mode    = dm3_q;
  assign out_o.length_bytes = len3_q;
  assign out_o.cycle_count  = cyc3_q;

endmodule

// File: rtl/core/mcuid_checker.sv
// Port-level checks for the instruction decoder, bound to the top level.
// Depends on mcuid_pkg for format, mode and jump codes; sees only clock, reset and output ports.
module mcuid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       illegal_i,
  input logic [1:0] format_i,
  input logic [5:0] operation_i,
  input logic       byte_op_i,
  input logic [2:0] source_mode_i,
  input logic [2:0] dest_mode_i,
  input logic [2:0] length_bytes_i,
  input logic [2:0] cycle_count_i
);
  import mcuid_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(operation_i)
      && $stable(illegal_i) && $stable(cycle_count_i) && $stable(length_bytes_i))
    else $error("stalled result changed");

  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && illegal_i |-> format_i == FMT_DOUBLE && operation_i == 6'd0 && !byte_op_i
      && source_mode_i == MODE_REG && dest_mode_i == MODE_REG && length_bytes_i == 3'd0
      && cycle_count_i == 3'd0)
    else $error("illegal result carries non-zero fields");

  a_legal_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !illegal_i |-> (length_bytes_i == 3'd2 || length_bytes_i == 3'd4
      || length_bytes_i == 3'd6) && cycle_count_i != 3'd0 && cycle_count_i != 3'd7)
    else $error("length or cycle count out of range");

  a_jump_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !illegal_i && format_i == FMT_JUMP |-> length_bytes_i == 3'd2
      && cycle_count_i == 3'd2 && source_mode_i == MODE_REG && dest_mode_i == MODE_REG
      && !byte_op_i && operation_i >= OP_JUMP_BASE && operation_i <= OP_JUMP_BASE + 6'd7)
    else $error("malformed jump result");

endmodule

bind mcu_instruction_decoder_top mcuid_checker u_mcuid_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .illegal_i      (out_o.illegal),
  .format_i       (out_o.format),
  .operation_i    (out_o.operation),
  .byte_op_i      (out_o.byte_op),
  .source_mode_i  (out_o.source_mode),
  .dest_mode_i    (out_o.dest_mode),
  .length_bytes_i (out_o.length_bytes),
  .cycle_count_i  (out_o.cycle_count)
);
